// ----- design/arps_pkg.sv -----
// shared types and constants of the annulus point sampler
package arps_pkg;

   // field and datapath widths
   localparam int RADIUS_W   = 16;
   localparam int COORD_W    = 17;
   localparam int TRIES_W    = 7;
   localparam int LCG_W      = 31;
   localparam int MUL_W      = 2 * LCG_W;
   localparam int PROD_W     = RADIUS_W + LCG_W;
   localparam int SQ_W       = 33;
   localparam int NORM_W     = SQ_W + 1;
   localparam int RSQ_W      = 2 * RADIUS_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // generator constants
   localparam logic [LCG_W-1:0] LCG_MUL  = 31'd1103515245;
   localparam logic [LCG_W-1:0] LCG_INC  = 31'd12345;
   localparam logic [LCG_W-1:0] LCG_SEED = 31'd15;

   // register reset values
   localparam logic [RADIUS_W-1:0] RESET_OUTER = 16'd12288;
   localparam logic [RADIUS_W-1:0] RESET_INNER = 16'd0;

   localparam int ARPS_MAX_TRIES = 64;

   // register word index
   typedef enum logic {
      REG_OUTER = 1'b0,
      REG_INNER = 1'b1
   } reg_idx_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [TRIES_W-1:0]        tries_type;

endpackage

// ----- design/arps_req_if.sv -----
// request channel of the annulus point sampler
interface arps_req_if import arps_pkg::*; ();
   logic valid;
   logic ready;
   logic request;

   modport source (output valid, output request, input ready);
   modport sink   (input valid, input request, output ready);
endinterface

// ----- design/arps_rsp_if.sv -----
// result channel of the annulus point sampler
interface arps_rsp_if import arps_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type coord_x;
   coord_type coord_y;
   tries_type tries_used;
   logic      gave_up;

   modport source (output valid, output coord_x, output coord_y, output tries_used,
                   output gave_up, input ready);
   modport sink   (input valid, input coord_x, input coord_y, input tries_used,
                   input gave_up, output ready);
endinterface

// ----- design/annulus_rejection_point_sampler_core.sv -----
// annulus rejection point sampler: one random point inside an annulus per request beat
//
// Usage: a req beat with request set asks for one point; a beat with request clear is
// taken and ignored. Each point comes back as one rsp beat with signed Q4.12 coordinates,
// the number of pairs drawn and a flag set when the try limit ran out.
// The radii are written over the csr port (word 0 outer, word 1 inner, unsigned Q4.12)
// while the block is idle.
// Timing: one 31x31 multiplier is shared by every multiply step. After a request beat
// the outer and inner radii are squared; then each try runs two generator steps, two
// scalings, two squares and one compare. The result beat follows once a pair lies in
// the ring or the try limit runs out (tries from 1 to MAX_TRIES).
// req.ready is high only while no point is being worked on.
// Stalls: the result sits in an output register; a new request is taken while it waits,
// and the sampler holds its finished point until the register is free.
// Reset: the generator returns to seed 15, the radii to 3.0 and 0.0, both channels empty.
module annulus_rejection_point_sampler_core import arps_pkg::*; #(
   parameter int MAX_TRIES = ARPS_MAX_TRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   arps_req_if.sink              req,
   arps_rsp_if.source            rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_PREP_O  = 11'b000_0000_0010,
      ST_PREP_I  = 11'b000_0000_0100,
      ST_DRAW_X  = 11'b000_0000_1000,
      ST_SCALE_X = 11'b000_0001_0000,
      ST_DRAW_Y  = 11'b000_0010_0000,
      ST_SCALE_Y = 11'b000_0100_0000,
      ST_SQ_X    = 11'b000_1000_0000,
      ST_SQ_Y    = 11'b001_0000_0000,
      ST_CHECK   = 11'b010_0000_0000,
      ST_FINISH  = 11'b100_0000_0000
   } state_type;

   localparam tries_type TRY_LIMIT = TRIES_W'(MAX_TRIES);

   state_type              state_ff,  state_in;
   logic [RADIUS_W-1:0]    outer_ff,  outer_in;
   logic [RADIUS_W-1:0]    inner_ff,  inner_in;
   logic [RSQ_W-1:0]       outer_sq_ff, outer_sq_in;
   logic [RSQ_W-1:0]       inner_sq_ff, inner_sq_in;
   logic [LCG_W-1:0]       lcg_ff,    lcg_in;
   logic [PROD_W-1:0]      prod_ff,   prod_in;
   coord_type              x_ff,      x_in;
   coord_type              y_ff,      y_in;
   logic [COORD_W-1:0]     xmag_ff,   xmag_in;
   logic [COORD_W-1:0]     ymag_ff,   ymag_in;
   logic [SQ_W-1:0]        sqx_ff,    sqx_in;
   tries_type              try_ff,    try_in;
   logic                   gave_ff,   gave_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   coord_type              rsp_x_ff;
   coord_type              rsp_y_ff;
   tries_type              rsp_tries_ff;
   logic                   rsp_gave_ff;

   logic                   load_out;
   logic [LCG_W-1:0]       mul_a;
   logic [LCG_W-1:0]       mul_b;
   logic [MUL_W-1:0]       mul_p;
   logic [LCG_W-1:0]       lcg_step;
   logic [COORD_W:0]       coord_wide;
   coord_type              coord_now;
   logic [COORD_W-1:0]     mag_now;
   logic [NORM_W-1:0]      norm_sum;
   logic                   in_ring;
   tries_type              try_next;
   logic                   csr_wr;
   reg_idx_type            csr_idx;

   // shared multiplier
   assign mul_p    = MUL_W'(mul_a) * MUL_W'(mul_b);
   assign lcg_step = mul_p[LCG_W-1:0] + LCG_INC;

   // coordinate from the scaled draw, and its magnitude
   assign coord_wide = {1'b0, prod_ff[PROD_W-1:PROD_W-COORD_W]}
                     - {2'b00, outer_ff};
   assign coord_now  = coord_wide[COORD_W-1:0];
   assign mag_now    = coord_now[COORD_W-1] ? COORD_W'(-coord_now) : coord_now;

   // squared norm and ring test
   assign norm_sum = {1'b0, sqx_ff} + {1'b0, prod_ff[SQ_W-1:0]};
   assign in_ring  = (norm_sum < NORM_W'(outer_sq_ff)) && (norm_sum > NORM_W'(inner_sq_ff));
   assign try_next = try_ff + 1'b1;

   // register port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1]);
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_idx)
         REG_OUTER: csr_prdata = CSR_DATA_W'(outer_ff);
         REG_INNER: csr_prdata = CSR_DATA_W'(inner_ff);
         default:   csr_prdata = '0;
      endcase
   end

   always_comb begin
      outer_in = outer_ff;
      inner_in = inner_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_OUTER: outer_in = csr_pwdata[RADIUS_W-1:0];
            REG_INNER: inner_in = csr_pwdata[RADIUS_W-1:0];
            default:   ;
         endcase
      end
   end

   // sequencer and operand selection
   always_comb begin
      state_in     = state_ff;
      outer_sq_in  = outer_sq_ff;
      inner_sq_in  = inner_sq_ff;
      lcg_in       = lcg_ff;
      prod_in      = prod_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      xmag_in      = xmag_ff;
      ymag_in      = ymag_ff;
      sqx_in       = sqx_ff;
      try_in       = try_ff;
      gave_in      = gave_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      load_out     = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.request) begin
               try_in   = '0;
               state_in = ST_PREP_O;
            end
         end
         ST_PREP_O: begin
            mul_a       = LCG_W'(outer_ff);
            mul_b       = LCG_W'(outer_ff);
            outer_sq_in = mul_p[RSQ_W-1:0];
            state_in    = ST_PREP_I;
         end
         ST_PREP_I: begin
            mul_a       = LCG_W'(inner_ff);
            mul_b       = LCG_W'(inner_ff);
            inner_sq_in = mul_p[RSQ_W-1:0];
            state_in    = ST_DRAW_X;
         end
         ST_DRAW_X: begin
            mul_a    = lcg_ff;
            mul_b    = LCG_MUL;
            lcg_in   = lcg_step;
            state_in = ST_SCALE_X;
         end
         ST_SCALE_X: begin
            mul_a    = LCG_W'(outer_ff);
            mul_b    = lcg_ff;
            prod_in  = mul_p[PROD_W-1:0];
            state_in = ST_DRAW_Y;
         end
         ST_DRAW_Y: begin
            x_in     = coord_now;
            xmag_in  = mag_now;
            mul_a    = lcg_ff;
            mul_b    = LCG_MUL;
            lcg_in   = lcg_step;
            state_in = ST_SCALE_Y;
         end
         ST_SCALE_Y: begin
            mul_a    = LCG_W'(outer_ff);
            mul_b    = lcg_ff;
            prod_in  = mul_p[PROD_W-1:0];
            state_in = ST_SQ_X;
         end
         ST_SQ_X: begin
            y_in     = coord_now;
            ymag_in  = mag_now;
            mul_a    = LCG_W'(xmag_ff);
            mul_b    = LCG_W'(xmag_ff);
            prod_in  = mul_p[PROD_W-1:0];
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            sqx_in   = prod_ff[SQ_W-1:0];
            mul_a    = LCG_W'(ymag_ff);
            mul_b    = LCG_W'(ymag_ff);
            prod_in  = mul_p[PROD_W-1:0];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            try_in = try_next;
            if (in_ring || (try_next == TRY_LIMIT)) begin
               gave_in  = !in_ring;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DRAW_X;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         outer_ff     <= RESET_OUTER;
         inner_ff     <= RESET_INNER;
         lcg_ff       <= LCG_SEED;
         try_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         outer_ff     <= outer_in;
         inner_ff     <= inner_in;
         lcg_ff       <= lcg_in;
         try_ff       <= try_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      outer_sq_ff <= outer_sq_in;
      inner_sq_ff <= inner_sq_in;
      prod_ff     <= prod_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      xmag_ff     <= xmag_in;
      ymag_ff     <= ymag_in;
      sqx_ff      <= sqx_in;
      gave_ff     <= gave_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_x_ff     <= x_ff;
         rsp_y_ff     <= y_ff;
         rsp_tries_ff <= try_ff;
         rsp_gave_ff  <= gave_ff;
      end
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.coord_x    = rsp_x_ff;
   assign rsp.coord_y    = rsp_y_ff;
   assign rsp.tries_used = rsp_tries_ff;
   assign rsp.gave_up    = rsp_gave_ff;

   // a loaded result has a try count within the limit
   a_tries_range: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (rsp.tries_used != '0) && (rsp.tries_used <= TRY_LIMIT))
      else $error("result try count out of range");

   // giving up only happens at the try limit
   a_gave_up_limit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.gave_up |-> rsp.tries_used == TRY_LIMIT)
      else $error("gave up before the try limit");

   // another try is started only below the limit
   a_retry_below_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) && (state_in == ST_DRAW_X) |=> try_ff < TRY_LIMIT)
      else $error("retry past the try limit");

   // the generator advances only in its draw steps
   a_lcg_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && (state_ff != ST_DRAW_X) && (state_ff != ST_DRAW_Y) |=> $stable(lcg_ff))
      else $error("generator stepped outside a draw");

endmodule

// ----- test/annulus_rejection_point_sampler_core_tb.sv -----
// testbench of the annulus rejection point sampler core
module annulus_rejection_point_sampler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import arps_pkg::*;

   localparam int IDLE_SETTLE = 16;
   localparam int DRAIN_TAIL  = 40;
   localparam int PHASES      = 12;

   typedef struct packed {
      coord_type x;
      coord_type y;
      tries_type tries;
      logic      gave_up;
   } annulus_point_type;

   // expected points, worked out from the radii and generator state at each request beat
   class point_scoreboard;
      logic [RADIUS_W-1:0] outer_r;
      logic [RADIUS_W-1:0] inner_r;
      logic [LCG_W-1:0]    lcg_state;
      annulus_point_type   pending_points[$];
      int                  errors;

      function new();
         outer_r   = RESET_OUTER;
         inner_r   = RESET_INNER;
         lcg_state = LCG_SEED;
         errors    = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("mismatch: %s", msg);
      endfunction

      // rejection loop: draw x, y until the pair is strictly in the ring or tries run out
      function annulus_point_type draw_annulus_point(inout logic [LCG_W-1:0] seed,
                                                     input logic [RADIUS_W-1:0] outer,
                                                     input logic [RADIUS_W-1:0] inner);
         annulus_point_type   pt;
         logic [PROD_W-1:0]   prod;
         logic [COORD_W-1:0]  scaled;
         logic [COORD_W-1:0]  mag;
         logic [RSQ_W-1:0]    outer_sq;
         logic [RSQ_W-1:0]    inner_sq;
         logic [NORM_W-1:0]   norm;
         logic                accepted;
         coord_type           xy[2];
         pt       = '0;
         accepted = 1'b0;
         xy[0]    = '0;
         xy[1]    = '0;
         outer_sq = RSQ_W'(outer) * RSQ_W'(outer);
         inner_sq = RSQ_W'(inner) * RSQ_W'(inner);
         for (int t = 1; t <= ARPS_MAX_TRIES && !accepted; t++) begin
            norm = '0;
            for (int k = 0; k < 2; k++) begin
               // generator step, mod 2^31 by the width of seed
               seed   = seed * LCG_MUL + LCG_INC;
               prod   = PROD_W'(outer) * PROD_W'(seed);
               scaled = prod[PROD_W-1:LCG_W-1];
               xy[k]  = coord_type'($signed({1'b0, scaled}) - $signed({2'b00, outer}));
               mag    = xy[k][COORD_W-1] ? COORD_W'(-xy[k]) : COORD_W'(xy[k]);
               norm   = norm + NORM_W'(mag) * NORM_W'(mag);
            end
            accepted = (norm < NORM_W'(outer_sq)) && (norm > NORM_W'(inner_sq));
            pt.tries = tries_type'(t);
         end
         pt.x       = xy[0];
         pt.y       = xy[1];
         pt.gave_up = !accepted;
         return pt;
      endfunction

      function void note_request(logic request);
         if (request) pending_points.push_back(draw_annulus_point(lcg_state, outer_r, inner_r));
      endfunction

      function void check_point(annulus_point_type got);
         annulus_point_type want;
         if (pending_points.size() == 0) begin
            flag($sformatf("unexpected point x=%0d y=%0d tries=%0d gave_up=%0b",
                           $signed(got.x), $signed(got.y), got.tries, got.gave_up));
            return;
         end
         want = pending_points.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.tries !== want.tries ||
             got.gave_up !== want.gave_up)
            flag($sformatf({"expected x=%0d y=%0d tries=%0d gave_up=%0b, ",
                            "got x=%0d y=%0d tries=%0d gave_up=%0b"},
                           $signed(want.x), $signed(want.y), want.tries, want.gave_up,
                           $signed(got.x), $signed(got.y), got.tries, got.gave_up));
      endfunction

      function void set_reg(reg_idx_type idx, logic [RADIUS_W-1:0] value);
         case (idx)
            REG_OUTER: outer_r = value;
            REG_INNER: inner_r = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_points.size();
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   arps_req_if req_bus ();
   arps_rsp_if rsp_bus ();

   point_scoreboard sb = new();

   annulus_rejection_point_sampler_core dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // beats seen on both channels at the rising edge
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) sb.note_request(req_bus.request);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_point({rsp_bus.coord_x, rsp_bus.coord_y, rsp_bus.tries_used, rsp_bus.gave_up});
   end

   // receiver back-pressure: free flow, random stalls, long slow toggles
   initial begin : rsp_stall
      int mode;
      int left;
      rsp_bus.ready = 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(20, 200);
         end
         left--;
         case (mode)
            0: rsp_bus.ready = 1'b1;
            1: rsp_bus.ready = ($urandom_range(0, 3) != 0);
            default: if ($urandom_range(0, 7) == 0) rsp_bus.ready = ~rsp_bus.ready;
         endcase
      end
   end

   // one request beat, held until taken
   task automatic send_beat(logic request);
      req_bus.valid   = 1'b1;
      req_bus.request = request;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         req_bus.valid = 1'b0;
         repeat (cycles) begin
            req_bus.request = $urandom_range(0, 1);
            @(negedge clock);
         end
      end
   endtask

   // hold off until every expected point is back and the core has settled
   task automatic wait_idle();
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   // register write followed by a read-back
   task automatic csr_write(reg_idx_type idx, logic [RADIUS_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      wait_idle();
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      if (readback[RADIUS_W-1:0] !== value)
         sb.flag($sformatf("register %s read back %0h, expected %0h",
                           idx.name(), readback[RADIUS_W-1:0], value));
   endtask

   task automatic set_radii(int outer, int inner);
      csr_write(REG_OUTER, RADIUS_W'(outer));
      csr_write(REG_INNER, RADIUS_W'(inner));
   endtask

   initial begin : stimulus
      int                  outer;
      int                  inner;
      int                  count;
      int                  sent;
      int                  burst;
      int                  found_inner;
      annulus_point_type   probe;
      logic [LCG_W-1:0]    seed_copy;
      req_bus.valid   = 1'b0;
      req_bus.request = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset radii, with ignored beats mixed in
      send_beat(1'b1);
      send_beat(1'b0);
      send_beat(1'b1);
      send_beat(1'b1);
      pause_sender(3);
      send_beat(1'b0);

      // largest outer radius, full disc
      set_radii(65535, 0);
      repeat (3) send_beat(1'b1);

      // empty ring: inner equal to outer
      csr_write(REG_INNER, 16'hFFFF);
      repeat (2) send_beat(1'b1);

      // smallest outer radius, nothing ever accepted
      set_radii(1, 0);
      repeat (2) send_beat(1'b1);

      // inner above outer
      set_radii(4096, 8192);
      send_beat(1'b1);

      // thin ring tuned so the next point is accepted on the final try
      csr_write(REG_OUTER, 16'hFFFF);
      found_inner = 64880;
      for (int c = 65534; c > 58000; c--) begin
         seed_copy = sb.lcg_state;
         probe = sb.draw_annulus_point(seed_copy, 16'hFFFF, RADIUS_W'(c));
         if (probe.tries == tries_type'(ARPS_MAX_TRIES) && !probe.gave_up) begin
            found_inner = c;
            break;
         end
      end
      csr_write(REG_INNER, RADIUS_W'(found_inner));
      send_beat(1'b1);

      // random phases, each with its own radii
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin outer = 12288; inner = 0;     count = 250; end
            1: begin outer = 65535; inner = 0;     count = 200; end
            2: begin outer = 65535; inner = 60000; count = 200; end
            3: begin outer = 1;     inner = 0;     count = 8;   end
            4: begin outer = 300;   inner = 100;   count = 150; end
            5: begin outer = 65535; inner = 65000; count = 40;  end
            default: begin
               outer = $urandom_range(64, 65535);
               inner = $urandom_range(0, outer - outer / 8);
               count = 160;
            end
         endcase
         set_radii(outer, inner);
         burst = 0;
         sent  = 0;
         while (sent < count) begin
            if (burst == 0) begin
               burst = $urandom_range(1, 16);
               if ($urandom_range(0, 49) == 0) wait_idle();
               else if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
            end
            if ($urandom_range(0, 7) == 0) begin
               send_beat(1'b0);
            end else begin
               send_beat(1'b1);
               sent++;
            end
            burst--;
         end
      end

      // drain and report
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
      if (sb.errors == 0) begin
         $display("annulus_rejection_point_sampler_core verification clean");
      end else begin
         $display("annulus_rejection_point_sampler_core verification failed");
      end
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin : watchdog
      #60ms;
      $display("annulus_rejection_point_sampler_core verification failed");
      $finish;
   end

endmodule
